// File: rtl/rdp_pkg.sv
// shared types, codes and defaults of the request dispatch pool
package rdp_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_SLOTS_DEF   = 16;
    localparam int RST_SLOTS       = 4;

    localparam int OPC_W   = 2;
    localparam int TAG_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 6;
    localparam int TMO_W   = 16;
    localparam int SCNT_W  = 5;
    localparam int WAIT_W  = 17;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] RST_LIMIT   = 6'd0;
    localparam logic [TMO_W-1:0]   RST_TIMEOUT = 16'd30;

    localparam logic [OPC_W-1:0] OP_SUBMIT  = 2'd0;
    localparam logic [OPC_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPC_W-1:0] OP_TICK    = 2'd2;

    localparam logic [KIND_W-1:0] EV_DISPATCHED = 2'd0;
    localparam logic [KIND_W-1:0] EV_QUEUED     = 2'd1;
    localparam logic [KIND_W-1:0] EV_REJECTED   = 2'd2;
    localparam logic [KIND_W-1:0] EV_TIMED_OUT  = 2'd3;

    localparam logic [1:0] REG_PENDING_LIMIT = 2'd0;
    localparam logic [1:0] REG_TIMEOUT       = 2'd1;
    localparam logic [1:0] REG_SLOT_COUNT    = 2'd2;

    // most negative wait count, decrements stop here
    localparam logic [WAIT_W-1:0] WAIT_FLOOR = 17'h10000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SERVE,
        S_DISP,
        S_QUEUED,
        S_WALK_RD,
        S_WALK_WR,
        S_TO_RD,
        S_TO_CHK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic refill;
        logic push;
        logic pop;
    } t_pool_cmd;

endpackage

// File: rtl/rdp_slot_pool.sv
// free connection slot stack with refill-by-index entries
module rdp_slot_pool #(
    parameter int MAX_SLOTS = rdp_pkg::MAX_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rdp_pkg::t_pool_cmd               i_cmd,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]   i_refill_count,
    input  logic [rdp_pkg::SLOT_W-1:0]       i_push_slot,
    output logic [$clog2(MAX_SLOTS+1)-1:0]   o_free_count,
    output logic [rdp_pkg::SLOT_W-1:0]       o_top_slot
);
    import rdp_pkg::*;

    localparam int FCW = $clog2(MAX_SLOTS + 1);
    localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_RST = (RST_SLOTS > MAX_SLOTS) ? MAX_SLOTS : RST_SLOTS;

    logic [SLOT_W-1:0]    r_stack [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_ovr;
    logic [FCW-1:0]       r_free;
    logic                 r_top_ovr;
    logic [SLOT_W-1:0]    r_top_mem;
    logic [SLOT_W-1:0]    r_top_idx;
    logic [IW-1:0]        w_top_addr;
    logic [IW-1:0]        w_push_addr;
    logic                 w_can_push;
    logic                 w_do_push;

    // an entry never pushed since the last refill holds its own index
    assign w_top_addr  = (r_free == '0) ? '0 : IW'(r_free - FCW'(1));
    assign w_push_addr = IW'(r_free);
    assign w_can_push  = r_free < FCW'(MAX_SLOTS);
    assign w_do_push   = !i_cmd.refill && i_cmd.push && w_can_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= FCW'(SLOT_RST);
            r_ovr  <= '0;
        end else if (i_cmd.refill) begin
            r_free <= i_refill_count;
            r_ovr  <= '0;
        end else if (w_do_push) begin
            r_ovr[w_push_addr] <= 1'b1;
            r_free             <= r_free + FCW'(1);
        end else if (i_cmd.pop) begin
            r_free <= r_free - FCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_stack[w_push_addr] <= i_push_slot;
        end
        r_top_mem <= r_stack[w_top_addr];
        r_top_ovr <= r_ovr[w_top_addr];
        r_top_idx <= SLOT_W'(w_top_addr);
    end

    assign o_free_count = r_free;
    assign o_top_slot   = r_top_ovr ? r_top_mem : r_top_idx;

endmodule

// File: rtl/request_dispatch_pool_with_timeout.sv
// top level of the request dispatcher with slot pool and wait timeout
//
// input channel: i_valid / o_stall carry one word (opcode, request tag, slot id);
// a word is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry result words (event kind, tag, slot,
// last); o_last marks the final result word of one input word
// one input word is worked on at a time; o_stall stays high until every result
// of that word has entered the output register
// steps of one word: a submit is rejected when the queue is full or at a nonzero
// pending limit; a release, an accepted submit and a tick first serve the queue,
// one dispatched result per free slot and waiting request, oldest first
// a submit then adds a queued notice if requests still wait; a tick walks every
// waiting request, reading its wait count and writing it back decremented in
// separate states, then times out expired requests from the head on
// the queue memory has one read and one write port
// a stalled receiver holds the output register; the sequencer waits with it
// reset (synchronous, active low) empties the queue, loads the default
// registers and refills the free slot stack with slots 0..3
// registers are to be written over the apb port only while no word is in flight,
// the block does not enforce it; a slot count write refills the free stack at once
module request_dispatch_pool_with_timeout #(
    parameter int QUEUE_DEPTH = rdp_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_SLOTS   = rdp_pkg::MAX_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rdp_pkg::OPC_W-1:0]   i_opcode,
    input  logic [rdp_pkg::TAG_W-1:0]   i_request_tag,
    input  logic [rdp_pkg::SLOT_W-1:0]  i_slot_id,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rdp_pkg::KIND_W-1:0]  o_event_kind,
    output logic [rdp_pkg::TAG_W-1:0]   o_tag_out,
    output logic [rdp_pkg::SLOT_W-1:0]  o_slot_out,
    output logic                        o_last,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rdp_pkg::ADDR_W-1:0]  paddr,
    input  logic [rdp_pkg::DATA_W-1:0]  pwdata,
    output logic [rdp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rdp_pkg::*;

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int FCW  = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_RST = (RST_SLOTS > MAX_SLOTS) ? MAX_SLOTS : RST_SLOTS;

    // head plus offset, wrapped around the queue ring
    function automatic logic [QW-1:0] f_wrap(input logic [QW-1:0] a,
                                             input logic [QW-1:0] b);
        logic [QW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (QW+1)'(QUEUE_DEPTH)) begin
            s = s - (QW+1)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    // config registers
    logic [LIMIT_W-1:0] r_limit;
    logic [TMO_W-1:0]   r_timeout;
    logic [SCNT_W-1:0]  r_slot_count;
    logic               w_cfg_wr;
    logic [1:0]         w_cfg_idx;
    logic [SCNT_W-1:0]  w_scnt_raw;
    logic [SCNT_W-1:0]  w_scnt_clamped;

    // sequencer state
    t_state             r_state, n_state;
    logic [OPC_W-1:0]   r_op, n_op;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [QW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;

    // one result held back until it is known whether it is the last
    logic               r_hold_valid, n_hold_valid;
    logic [KIND_W-1:0]  r_hold_kind, n_hold_kind;
    logic [TAG_W-1:0]   r_hold_tag, n_hold_tag;
    logic [SLOT_W-1:0]  r_hold_slot, n_hold_slot;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic               r_out_last, n_out_last;

    // queue memories
    logic [TAG_W-1:0]   r_tag_mem  [QUEUE_DEPTH];
    logic [WAIT_W-1:0]  r_wait_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]   r_rd_tag;
    logic [WAIT_W-1:0]  r_rd_wait;
    logic               w_tag_we;
    logic               w_wait_we;
    logic [QW-1:0]      w_wr_addr;
    logic [QW-1:0]      w_rd_addr;
    logic [WAIT_W-1:0]  w_wr_wait;

    // slot pool
    t_pool_cmd          w_pool_cmd;
    logic [FCW-1:0]     w_free_count;
    logic [SLOT_W-1:0]  w_top_slot;
    logic [FCW-1:0]     w_refill_count;

    // result emission
    logic               w_out_free;
    logic               w_emit_ok;
    logic               w_emit;
    logic [KIND_W-1:0]  w_emit_kind;
    logic [TAG_W-1:0]   w_emit_tag;
    logic [SLOT_W-1:0]  w_emit_slot;

    logic               w_limit_hit;
    logic               w_queue_full;
    logic               w_expired;
    logic [WAIT_W-1:0]  w_wait_dec;

    //--------------------------------------------------------------------
    // configuration port
    //--------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[3:2];

    // a slot count of zero acts as one, above the pool size as the pool size
    assign w_scnt_raw = pwdata[SCNT_W-1:0];
    always_comb begin
        w_scnt_clamped = w_scnt_raw;
        if (w_scnt_raw == '0) begin
            w_scnt_clamped = SCNT_W'(1);
        end else if (32'(w_scnt_raw) > 32'(MAX_SLOTS)) begin
            w_scnt_clamped = SCNT_W'(MAX_SLOTS);
        end
    end
    assign w_refill_count = FCW'(w_scnt_clamped);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= RST_LIMIT;
            r_timeout    <= RST_TIMEOUT;
            r_slot_count <= SCNT_W'(SLOT_RST);
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PENDING_LIMIT: r_limit      <= pwdata[LIMIT_W-1:0];
                REG_TIMEOUT:       r_timeout    <= pwdata[TMO_W-1:0];
                REG_SLOT_COUNT:    r_slot_count <= w_scnt_clamped;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_PENDING_LIMIT: prdata = DATA_W'(r_limit);
            REG_TIMEOUT:       prdata = DATA_W'(r_timeout);
            REG_SLOT_COUNT:    prdata = DATA_W'(r_slot_count);
            default:           prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // free slot stack
    //--------------------------------------------------------------------
    rdp_slot_pool #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_pool (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_pool_cmd),
        .i_refill_count (w_refill_count),
        .i_push_slot    (i_slot_id),
        .o_free_count   (w_free_count),
        .o_top_slot     (w_top_slot)
    );

    //--------------------------------------------------------------------
    // queue memories, one write and one registered read per cycle
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_wr_addr] <= i_request_tag;
        end
        if (w_wait_we) begin
            r_wait_mem[w_wr_addr] <= w_wr_wait;
        end
        r_rd_tag  <= r_tag_mem[w_rd_addr];
        r_rd_wait <= r_wait_mem[w_rd_addr];
    end

    //--------------------------------------------------------------------
    // sequencer
    //--------------------------------------------------------------------
    assign o_stall = (r_state != S_IDLE);

    assign w_limit_hit  = (r_limit != '0) && (CMPW'(r_count) >= CMPW'(r_limit));
    assign w_queue_full = (r_count == CW'(QUEUE_DEPTH));

    // wait count at or below zero means the request ran out of time
    assign w_expired  = r_rd_wait[WAIT_W-1] || (r_rd_wait == '0);
    // saturating decrement
    assign w_wait_dec = (r_rd_wait == WAIT_FLOOR) ? r_rd_wait : r_rd_wait - WAIT_W'(1);

    // a new result can be taken when the held one can move to the output
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_emit_ok  = !r_hold_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_tag       <= n_tag;
        r_idx       <= n_idx;
        r_hold_kind <= n_hold_kind;
        r_hold_tag  <= n_hold_tag;
        r_hold_slot <= n_hold_slot;
        r_out_kind  <= n_out_kind;
        r_out_tag   <= n_out_tag;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_tag        = r_tag;
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_hold_valid = r_hold_valid;
        n_hold_kind  = r_hold_kind;
        n_hold_tag   = r_hold_tag;
        n_hold_slot  = r_hold_slot;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_tag    = r_out_tag;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;

        w_tag_we     = 1'b0;
        w_wait_we    = 1'b0;
        w_wr_addr    = f_wrap(r_head, QW'(r_count));
        w_wr_wait    = {1'b0, r_timeout};
        w_rd_addr    = r_head;

        w_pool_cmd        = '0;
        w_pool_cmd.refill = w_cfg_wr && (w_cfg_idx == REG_SLOT_COUNT);

        w_emit       = 1'b0;
        w_emit_kind  = EV_DISPATCHED;
        w_emit_tag   = r_tag;
        w_emit_slot  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = i_opcode;
                    n_tag  = i_request_tag;
                    case (i_opcode)
                        OP_SUBMIT: begin
                            if (w_limit_hit || w_queue_full) begin
                                n_hold_valid = 1'b1;
                                n_hold_kind  = EV_REJECTED;
                                n_hold_tag   = i_request_tag;
                                n_hold_slot  = '0;
                                n_state      = S_FINISH;
                            end else begin
                                // append at the tail with a fresh wait count
                                w_tag_we  = 1'b1;
                                w_wait_we = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_state   = S_SERVE;
                            end
                        end
                        OP_RELEASE: begin
                            w_pool_cmd.push = 1'b1;
                            n_state         = S_SERVE;
                        end
                        OP_TICK: begin
                            n_state = S_SERVE;
                        end
                        default: ;
                    endcase
                end
            end

            // head tag and top slot are read here, used in the next state
            S_SERVE: begin
                if ((w_free_count != '0) && (r_count != '0)) begin
                    n_state = S_DISP;
                end else begin
                    case (r_op)
                        OP_SUBMIT: n_state = (r_count != '0) ? S_QUEUED : S_FINISH;
                        OP_TICK: begin
                            n_idx   = '0;
                            n_state = S_WALK_RD;
                        end
                        default:   n_state = S_FINISH;
                    endcase
                end
            end

            S_DISP: begin
                w_emit      = 1'b1;
                w_emit_kind = EV_DISPATCHED;
                w_emit_tag  = r_rd_tag;
                w_emit_slot = w_top_slot;
                if (w_emit_ok) begin
                    w_pool_cmd.pop = 1'b1;
                    n_head  = f_wrap(r_head, QW'(1));
                    n_count = r_count - CW'(1);
                    n_state = S_SERVE;
                end
            end

            S_QUEUED: begin
                w_emit      = 1'b1;
                w_emit_kind = EV_QUEUED;
                w_emit_tag  = r_tag;
                if (w_emit_ok) begin
                    n_state = S_FINISH;
                end
            end

            // walk every waiting entry: read, then write back decremented
            S_WALK_RD: begin
                if (r_idx < r_count) begin
                    w_rd_addr = f_wrap(r_head, QW'(r_idx));
                    n_state   = S_WALK_WR;
                end else begin
                    n_state = S_TO_RD;
                end
            end

            S_WALK_WR: begin
                w_wait_we = 1'b1;
                w_wr_addr = f_wrap(r_head, QW'(r_idx));
                w_wr_wait = w_wait_dec;
                n_idx     = r_idx + CW'(1);
                n_state   = S_WALK_RD;
            end

            S_TO_RD: begin
                n_state = (r_count != '0) ? S_TO_CHK : S_FINISH;
            end

            S_TO_CHK: begin
                if (w_expired) begin
                    w_emit      = 1'b1;
                    w_emit_kind = EV_TIMED_OUT;
                    w_emit_tag  = r_rd_tag;
                    if (w_emit_ok) begin
                        n_head  = f_wrap(r_head, QW'(1));
                        n_count = r_count - CW'(1);
                        n_state = S_TO_RD;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end

            // the held result is the last one of this word
            S_FINISH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_hold_kind;
                    n_out_tag    = r_hold_tag;
                    n_out_slot   = r_hold_slot;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // a new result pushes the held one out, not last
        if (w_emit && w_emit_ok) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_kind  = r_hold_kind;
                n_out_tag   = r_hold_tag;
                n_out_slot  = r_hold_slot;
                n_out_last  = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_kind  = w_emit_kind;
            n_hold_tag   = w_emit_tag;
            n_hold_slot  = w_emit_slot;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_tag_out    = r_out_tag;
    assign o_slot_out   = r_out_slot;
    assign o_last       = r_out_last;

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // no result may be left held back once the word is done
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held result left behind at idle");

    // a dispatch always has a free slot behind it
    a_disp_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && w_emit_ok) |-> (w_free_count != '0 && r_count != '0))
        else $error("dispatch without free slot or queued request");

    // queue count stays within the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // the last flag of a word always ends the word before idle
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_hold_valid && w_out_free) |=>
            (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final result not flagged last");

endmodule

// File: bench/tb_request_dispatch_pool_with_timeout.sv
// self-checking bench for the request dispatcher with slot pool and wait timeout
`timescale 1ns / 100ps

module tb_request_dispatch_pool_with_timeout;
    import rdp_pkg::*;

    // depth and pool size follow the block's defaults
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int MS = MAX_SLOTS_DEF;

    // opcode 3 has no meaning, the block must drop it silently
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    // wait counts stop falling at the most negative 17-bit value
    localparam int WAIT_MIN = -65536;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int SETTLE_CYCLES   = 200;   // idle time for a silent tick walk to finish
    localparam int MAX_REPORTS     = 10;
    localparam int IDLE_PCT        = 22;
    localparam int N_PLAN          = 25;
    localparam int N_PHASES        = 5;
    localparam int ITEMS_PER_PHASE = 56;

    // kinds of row in the directed plan
    localparam logic ROW_WORD  = 1'b0;
    localparam logic ROW_REG   = 1'b1;
    localparam logic CHK_PRED  = 1'b0;
    localparam logic CHK_TABLE = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result;

    localparam t_result NO_RESULT = '0;

    // one directed step: a word or a register write, with an optional typed result
    typedef struct packed {
        logic              is_reg;
        logic [1:0]        code;    // opcode or register index
        logic [15:0]       arg;     // request tag or register value
        logic [SLOT_W-1:0] sid;
        logic              typed;
        t_result           want;
    } t_row;

    // register setting and traffic mix of one random phase
    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [TMO_W-1:0]   tmo;
        logic [SCNT_W-1:0]  slots;
        logic [6:0]         sub_pct;
        logic [6:0]         rel_pct;
        logic               calm;
    } t_phase;

    // block ports
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [OPC_W-1:0]   i_opcode;
    logic [TAG_W-1:0]   i_request_tag;
    logic [SLOT_W-1:0]  i_slot_id;
    logic               o_valid;
    logic               i_stall;
    logic [KIND_W-1:0]  o_event_kind;
    logic [TAG_W-1:0]   o_tag_out;
    logic [SLOT_W-1:0]  o_slot_out;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // shadow of the dispatcher: waiting fifo, free slot stack, registers
    logic [TAG_W-1:0]  pq_tag [QD];
    int                pq_wait [QD];
    int                pq_head;
    int                pq_count;
    logic [SLOT_W-1:0] stk [MS];
    int                stk_cnt;
    int                lim;
    int                tmo;
    int                nslots;

    t_result step_out [$];   // results of the word just accepted
    t_result want_q [$];     // results still owed by the block, oldest first
    int      n_bad;
    bit      calm;           // no idling on either side while set

    t_row   plan [N_PLAN];
    t_phase phases [N_PHASES];

    request_dispatch_pool_with_timeout dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // shadow model
    // ---------------------------------------------------------------

    function automatic void add_result(logic [KIND_W-1:0] k, logic [TAG_W-1:0] t,
                                       logic [SLOT_W-1:0] s);
        t_result r;
        r.kind = k;
        r.tag  = t;
        r.slot = s;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // fresh stack holds 0..n-1, so the highest slot goes out first
    function automatic void refill_slots();
        int i;
        for (i = 0; i < nslots; i++)
            stk[i] = SLOT_W'(i);
        stk_cnt = nslots;
    endfunction

    // pair waiting requests with free slots, oldest request first
    function automatic void serve_queue();
        while (stk_cnt > 0 && pq_count > 0) begin
            stk_cnt--;
            add_result(EV_DISPATCHED, pq_tag[pq_head], stk[stk_cnt]);
            pq_head  = (pq_head + 1) % QD;
            pq_count--;
        end
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            REG_PENDING_LIMIT: lim = int'(val[LIMIT_W-1:0]);
            REG_TIMEOUT:       tmo = int'(val[TMO_W-1:0]);
            REG_SLOT_COUNT: begin
                // zero acts as one, anything above the pool size as the pool size
                nslots = int'(val[SCNT_W-1:0]);
                if (nslots == 0)
                    nslots = 1;
                if (nslots > MS)
                    nslots = MS;
                refill_slots();
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_word(logic [OPC_W-1:0] op, logic [TAG_W-1:0] tag,
                                         logic [SLOT_W-1:0] sid);
        int      p;
        int      i;
        t_result r;
        step_out.delete();
        case (op)
            OP_SUBMIT: begin
                if ((lim != 0 && pq_count >= lim) || pq_count >= QD) begin
                    add_result(EV_REJECTED, tag, '0);
                end else begin
                    p          = (pq_head + pq_count) % QD;
                    pq_tag[p]  = tag;
                    pq_wait[p] = tmo;
                    pq_count++;
                    serve_queue();
                    // still waiting after the serve: tell the sender it is queued
                    if (pq_count > 0)
                        add_result(EV_QUEUED, tag, '0);
                end
            end
            OP_RELEASE: begin
                // a push onto a full stack is dropped, the queue is served anyway
                if (stk_cnt < MS) begin
                    stk[stk_cnt] = sid;
                    stk_cnt++;
                end
                serve_queue();
            end
            OP_TICK: begin
                serve_queue();
                for (i = 0; i < pq_count; i++) begin
                    p = (pq_head + i) % QD;
                    if (pq_wait[p] > WAIT_MIN)
                        pq_wait[p]--;
                end
                // timeouts go from the head on; expired entries behind a waiting head stay
                while (pq_count > 0 && pq_wait[pq_head] <= 0) begin
                    add_result(EV_TIMED_OUT, pq_tag[pq_head], '0);
                    pq_head = (pq_head + 1) % QD;
                    pq_count--;
                end
            end
            default: ;
        endcase
        if (step_out.size() > 0) begin
            r      = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offer one word from a falling edge, wait for the accepting rising edge
    task automatic send_word(logic [OPC_W-1:0] op, logic [TAG_W-1:0] tag,
                             logic [SLOT_W-1:0] sid, logic keep_pred);
        int i;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_request_tag <= tag;
        i_slot_id     <= sid;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_word(op, tag, sid);
        if (keep_pred)
            for (i = 0; i < step_out.size(); i++)
                want_q.push_back(step_out[i]);
    endtask

    // stop sending, let every owed result come out, then let a silent tick walk finish
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, val);
    endtask

    // receiver holds off at random except during a calm phase
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_event_kind, o_tag_out, o_slot_out, o_last};
            if (want_q.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result word: kind %0d tag %h slot %0d last %0b",
                             got.kind, got.tag, got.slot, got.last);
            end else begin
                want = want_q.pop_front();
                if (got.kind !== want.kind || got.tag !== want.tag ||
                    got.slot !== want.slot || got.last !== want.last) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display({"result mismatch: expected kind %0d tag %h slot %0d ",
                                  "last %0b, got kind %0d tag %h slot %0d last %0b"},
                                 want.kind, want.tag, want.slot, want.last,
                                 got.kind, got.tag, got.slot, got.last);
                end
            end
        end
    end

    // hard stop if the block hangs
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_request_dispatch_pool_with_timeout: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial begin
        int               r;
        int               ph;
        int               k;
        int               roll;
        logic [OPC_W-1:0] op;

        // sender inputs known from time zero, receiver stall set at the first falling edge
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_SUBMIT;
        i_request_tag = '0;
        i_slot_id     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        n_bad         = 0;

        // shadow reset: default registers, empty queue, slots 0..3 free
        lim      = int'(RST_LIMIT);
        tmo      = int'(RST_TIMEOUT);
        nslots   = RST_SLOTS;
        pq_head  = 0;
        pq_count = 0;
        refill_slots();

        // directed plan, starting from the reset setting (4 slots, 30 tick wait)
        plan = '{
            // use up the pool, starting with extreme tags, highest slot first
            '{ROW_WORD, OP_SUBMIT,  16'h0000, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'h0000, 4'd3, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'hFFFF, 4'd15, CHK_TABLE,
              '{EV_DISPATCHED, 16'hFFFF, 4'd2, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'h1234, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'h1234, 4'd1, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'hABCD, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'hABCD, 4'd0, 1'b1}},
            // pool empty: requests wait
            '{ROW_WORD, OP_SUBMIT,  16'h5555, 4'd0,  CHK_TABLE,
              '{EV_QUEUED, 16'h5555, 4'd0, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'hAAAA, 4'd0,  CHK_TABLE,
              '{EV_QUEUED, 16'hAAAA, 4'd0, 1'b1}},
            // foreign slot released, goes straight to the head
            '{ROW_WORD, OP_RELEASE, 16'h0000, 4'd15, CHK_TABLE,
              '{EV_DISPATCHED, 16'h5555, 4'd15, 1'b1}},
            '{ROW_WORD, OP_UNUSED,  16'hFFFF, 4'd15, CHK_PRED,  NO_RESULT},
            '{ROW_WORD, OP_TICK,    16'h0000, 4'd0,  CHK_PRED,  NO_RESULT},
            '{ROW_WORD, OP_RELEASE, 16'h0000, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'hAAAA, 4'd0, 1'b1}},
            '{ROW_WORD, OP_RELEASE, 16'h0000, 4'd5,  CHK_PRED,  NO_RESULT},
            // zero wait: a queued request times out on the next tick
            '{ROW_REG,  REG_TIMEOUT, 16'd0,   4'd0,  CHK_PRED,  NO_RESULT},
            '{ROW_WORD, OP_SUBMIT,  16'h0001, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'h0001, 4'd5, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'h0002, 4'd0,  CHK_TABLE,
              '{EV_QUEUED, 16'h0002, 4'd0, 1'b1}},
            '{ROW_WORD, OP_TICK,    16'h0000, 4'd0,  CHK_TABLE,
              '{EV_TIMED_OUT, 16'h0002, 4'd0, 1'b1}},
            '{ROW_WORD, OP_TICK,    16'h0000, 4'd0,  CHK_PRED,  NO_RESULT},
            // pending limit of one: second waiter is turned away
            '{ROW_REG,  REG_PENDING_LIMIT, 16'd1, 4'd0, CHK_PRED, NO_RESULT},
            '{ROW_WORD, OP_SUBMIT,  16'h0003, 4'd0,  CHK_TABLE,
              '{EV_QUEUED, 16'h0003, 4'd0, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'h0004, 4'd0,  CHK_TABLE,
              '{EV_REJECTED, 16'h0004, 4'd0, 1'b1}},
            // slot count zero acts as one and does not serve the waiter
            '{ROW_REG,  REG_SLOT_COUNT, 16'd0, 4'd0, CHK_PRED,  NO_RESULT},
            '{ROW_WORD, OP_RELEASE, 16'h0000, 4'd9,  CHK_TABLE,
              '{EV_DISPATCHED, 16'h0003, 4'd9, 1'b1}},
            // oversized slot count clamps to the full pool; release onto a full stack
            '{ROW_REG,  REG_SLOT_COUNT, 16'd31, 4'd0, CHK_PRED, NO_RESULT},
            '{ROW_WORD, OP_RELEASE, 16'h0000, 4'd7,  CHK_PRED,  NO_RESULT},
            '{ROW_WORD, OP_SUBMIT,  16'h0005, 4'd0,  CHK_TABLE,
              '{EV_DISPATCHED, 16'h0005, 4'd15, 1'b1}},
            '{ROW_WORD, OP_SUBMIT,  16'h0006, 4'd0,  CHK_PRED,  NO_RESULT}
        };

        // random phases: limit, wait, slots, submit %, release %, calm
        phases = '{
            '{6'd0,  16'd65535, 5'd2,  7'd80, 7'd5,  1'b0},   // fill the fifo to its depth
            '{6'd32, 16'd3,     5'd16, 7'd45, 7'd30, 1'b0},   // mixed waits behind long ones
            '{6'd5,  16'd1,     5'd1,  7'd50, 7'd30, 1'b1},   // single slot, no idling
            '{6'd0,  16'd0,     5'd20, 7'd55, 7'd25, 1'b0},   // instant timeouts, clamped pool
            '{6'd63, 16'd2,     5'd3,  7'd50, 7'd30, 1'b0}    // limit beyond the depth
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (r = 0; r < N_PLAN; r++) begin
            if (plan[r].is_reg == ROW_REG) begin
                settle();
                write_reg(plan[r].code, plan[r].arg);
            end else begin
                send_word(plan[r].code, plan[r].arg, plan[r].sid, plan[r].typed == CHK_PRED);
                if (plan[r].typed == CHK_TABLE)
                    want_q.push_back(plan[r].want);
            end
        end

        // random part; the fifo carries over from one phase into the next
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            calm = phases[ph].calm;
            write_reg(REG_PENDING_LIMIT, 16'(phases[ph].limit));
            write_reg(REG_TIMEOUT, phases[ph].tmo);
            write_reg(REG_SLOT_COUNT, 16'(phases[ph].slots));
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // halfway through, hold the sender until the block has caught up
                if (k == ITEMS_PER_PHASE / 2)
                    settle();
                roll = $urandom_range(0, 99);
                if (roll < phases[ph].sub_pct)
                    op = OP_SUBMIT;
                else if (roll < phases[ph].sub_pct + phases[ph].rel_pct)
                    op = OP_RELEASE;
                else if (roll < 95)
                    op = OP_TICK;
                else
                    op = OP_UNUSED;
                send_word(op, TAG_W'($urandom), SLOT_W'($urandom), 1'b1);
            end
        end

        calm = 1'b0;
        settle();
        if (n_bad == 0 && want_q.size() == 0) begin
            $display("tb_request_dispatch_pool_with_timeout: PASS");
        end else begin
            $display("tb_request_dispatch_pool_with_timeout: FAIL");
        end
        $finish;
    end

endmodule
